// File: rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
// Sampled on the rising edge of i_clk and masked while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every edge outside reset.
`define CFSA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Condition must never be seen outside reset.
`define CFSA_NEVER(lbl, cond, msg) \
    `CFSA_ASSERT(lbl, !(cond), msg)

`endif

// File: rtl/cfsa_pkg.sv
`timescale 1ns / 1ps

package cfsa_pkg;

    localparam logic [7:0] CH_CR         = 8'h0D;
    localparam logic [7:0] CH_ZERO       = 8'h30;
    localparam logic [7:0] CH_ALPHA_BASE = 8'h37;  // 'A' minus ten
    localparam logic [3:0] LEN_PREFIX    = 4'h3;
    localparam logic [7:0] CH_STD_DATA   = 8'h74;  // 't'
    localparam logic [7:0] CH_EXT_DATA   = 8'h54;  // 'T'
    localparam logic [7:0] CH_STD_REMOTE = 8'h72;  // 'r'
    localparam logic [7:0] CH_EXT_REMOTE = 8'h52;  // 'R'

    localparam logic [3:0] MAX_BYTES     = 4'd8;
    localparam logic [3:0] ID_DIGITS_STD = 4'd3;
    localparam logic [3:0] ID_DIGITS_EXT = 4'd8;

    // One classified frame, ready for the character sequencer.
    typedef struct packed {
        logic [7:0]  type_ch;
        logic [31:0] id_word;     // identifier digits, most significant nibble first
        logic [3:0]  id_digits;
        logic [7:0]  len_ch;
        logic [3:0]  byte_count;
        logic [63:0] payload;
    } t_job;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TYPE,
        S_ID,
        S_LEN,
        S_DATA,
        S_EOL
    } t_phase;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] wide;
        wide = {4'b0000, nib};
        return (nib < 4'd10) ? (CH_ZERO + wide) : (CH_ALPHA_BASE + wide);
    endfunction

endpackage

// File: rtl/cfsa_front.sv
`timescale 1ns / 1ps

module cfsa_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [28:0]        i_frame_id,
    input  logic               i_is_extended,
    input  logic               i_is_remote,
    input  logic [3:0]         i_length_code,
    input  logic [63:0]        i_payload,
    output logic               o_job_valid,
    output cfsa_pkg::t_job     o_job,
    input  logic               i_job_take
);

    cfsa_pkg::t_job w_job;
    cfsa_pkg::t_job r_q [2];
    logic           r_wr_ptr, n_wr_ptr;
    logic           r_rd_ptr, n_rd_ptr;
    logic [1:0]     r_cnt, n_cnt;
    logic           w_wr;
    logic           w_rd;

    always_comb begin
        if (i_is_remote) begin
            w_job.type_ch = i_is_extended ? cfsa_pkg::CH_EXT_REMOTE : cfsa_pkg::CH_STD_REMOTE;
        end else begin
            w_job.type_ch = i_is_extended ? cfsa_pkg::CH_EXT_DATA : cfsa_pkg::CH_STD_DATA;
        end
        // Left-align the id digits; a standard id keeps bits 10..0 only.
        if (i_is_extended) begin
            w_job.id_word   = {3'b000, i_frame_id};
            w_job.id_digits = cfsa_pkg::ID_DIGITS_EXT;
        end else begin
            w_job.id_word   = {1'b0, i_frame_id[10:0], 20'd0};
            w_job.id_digits = cfsa_pkg::ID_DIGITS_STD;
        end
        w_job.len_ch     = {cfsa_pkg::LEN_PREFIX, i_length_code};
        w_job.byte_count = (i_length_code > cfsa_pkg::MAX_BYTES) ? cfsa_pkg::MAX_BYTES
                                                                 : i_length_code;
        w_job.payload    = i_payload;
    end

    assign full        = (r_cnt == 2'd2);
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_q[r_rd_ptr];
    assign w_wr        = push && !full;
    assign w_rd        = i_job_take && o_job_valid;

    always_comb begin
        n_wr_ptr = w_wr ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = w_rd ? ~r_rd_ptr : r_rd_ptr;
        n_cnt    = r_cnt + {1'b0, w_wr} - {1'b0, w_rd};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_q[r_wr_ptr] <= w_job;
        end
    end

endmodule

// File: rtl/cfsa_back.sv
`timescale 1ns / 1ps

module cfsa_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_job_valid,
    input  cfsa_pkg::t_job     i_job,
    output logic               o_job_take,
    output logic               empty,
    input  logic               pop,
    output logic [7:0]         o_ascii_char,
    output logic               o_end_of_line
);

    cfsa_pkg::t_phase r_state, n_state;

    logic [7:0]  r_type_ch;
    logic [31:0] r_id_word;
    logic [3:0]  r_id_left;
    logic [7:0]  r_len_ch;
    logic [3:0]  r_bytes_left;
    logic        r_low_nib;
    logic [63:0] r_data;

    logic        r_out_valid;
    logic [7:0]  r_out_char;
    logic        r_out_eol;

    logic        w_free;
    logic        w_emit;
    logic [7:0]  w_char;
    logic        w_eol;

    assign w_free = !r_out_valid || pop;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cfsa_pkg::S_IDLE: begin
                if (i_job_valid) n_state = cfsa_pkg::S_TYPE;
            end
            cfsa_pkg::S_TYPE: begin
                if (w_free) n_state = cfsa_pkg::S_ID;
            end
            cfsa_pkg::S_ID: begin
                if (w_free && r_id_left == 4'd1) n_state = cfsa_pkg::S_LEN;
            end
            cfsa_pkg::S_LEN: begin
                if (w_free) begin
                    n_state = (r_bytes_left == 4'd0) ? cfsa_pkg::S_EOL : cfsa_pkg::S_DATA;
                end
            end
            cfsa_pkg::S_DATA: begin
                if (w_free && r_low_nib && r_bytes_left == 4'd1) n_state = cfsa_pkg::S_EOL;
            end
            cfsa_pkg::S_EOL: begin
                if (w_free) n_state = cfsa_pkg::S_IDLE;
            end
            default: n_state = cfsa_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_job_take = 1'b0;
        w_emit     = 1'b1;
        w_eol      = 1'b0;
        w_char     = r_type_ch;
        unique case (r_state)
            cfsa_pkg::S_IDLE: begin
                o_job_take = i_job_valid;
                w_emit     = 1'b0;
            end
            cfsa_pkg::S_TYPE: w_char = r_type_ch;
            cfsa_pkg::S_ID:   w_char = cfsa_pkg::hex_char(r_id_word[31:28]);
            cfsa_pkg::S_LEN:  w_char = r_len_ch;
            cfsa_pkg::S_DATA: begin
                w_char = cfsa_pkg::hex_char(r_low_nib ? r_data[3:0] : r_data[7:4]);
            end
            cfsa_pkg::S_EOL: begin
                w_char = cfsa_pkg::CH_CR;
                w_eol  = 1'b1;
            end
            default: w_emit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cfsa_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_free) begin
                r_out_valid <= w_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_free) begin
            r_out_char <= w_char;
            r_out_eol  <= w_eol;
        end
        if (o_job_take) begin
            r_type_ch    <= i_job.type_ch;
            r_id_word    <= i_job.id_word;
            r_id_left    <= i_job.id_digits;
            r_len_ch     <= i_job.len_ch;
            r_bytes_left <= i_job.byte_count;
            r_data       <= i_job.payload;
            r_low_nib    <= 1'b0;
        end else if (w_free && r_state == cfsa_pkg::S_ID) begin
            // advance to the next id digit
            r_id_word <= {r_id_word[27:0], 4'h0};
            r_id_left <= r_id_left - 4'd1;
        end else if (w_free && r_state == cfsa_pkg::S_DATA) begin
            r_low_nib <= ~r_low_nib;
            if (r_low_nib) begin
                r_data       <= {8'h00, r_data[63:8]};
                r_bytes_left <= r_bytes_left - 4'd1;
            end
        end
    end

    assign empty         = !r_out_valid;
    assign o_ascii_char  = r_out_char;
    assign o_end_of_line = r_out_eol;

endmodule

// File: rtl/can_frame_to_slcan_ascii.sv
// CAN frame to SLCAN line encoder.
// Input channel: present a frame on i_frame_id, i_is_extended, i_is_remote,
// i_length_code and i_payload with push high; it is taken on an edge where
// full is low. A two-entry frame queue sits behind the input.
// Output channel: one ASCII character per item on o_ascii_char; o_end_of_line
// marks the closing carriage return. A character is shown while empty is low
// and taken on an edge where pop is high.
// A frame accepted while the sequencer is idle passes the frame queue,
// the sequencer's load from idle and the output register before its type
// letter appears. A line holds 6 to 27 characters; the character
// sequencer emits one character per cycle while the receiver does not
// stall, and passes through its idle state to load the next frame.
// Reset (synchronous, active low) empties the frame queue, returns the
// sequencer to idle and drops any character in the output register.
// When the receiver stalls the current character holds, the sequencer
// waits, and the queue keeps taking frames until it is full.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module can_frame_to_slcan_ascii (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [28:0] i_frame_id,
    input  logic        i_is_extended,
    input  logic        i_is_remote,
    input  logic [3:0]  i_length_code,
    input  logic [63:0] i_payload,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_ascii_char,
    output logic        o_end_of_line
);

    cfsa_pkg::t_job w_job;
    logic           w_job_valid;
    logic           w_job_take;

    cfsa_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_frame_id    (i_frame_id),
        .i_is_extended (i_is_extended),
        .i_is_remote   (i_is_remote),
        .i_length_code (i_length_code),
        .i_payload     (i_payload),
        .o_job_valid   (w_job_valid),
        .o_job         (w_job),
        .i_job_take    (w_job_take)
    );

    cfsa_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_valid   (w_job_valid),
        .i_job         (w_job),
        .o_job_take    (w_job_take),
        .empty         (empty),
        .pop           (pop),
        .o_ascii_char  (o_ascii_char),
        .o_end_of_line (o_end_of_line)
    );

    `CFSA_ASSERT(a_eol_is_cr, (!empty && o_end_of_line) |-> (o_ascii_char == cfsa_pkg::CH_CR), "end of line without carriage return")
    `CFSA_NEVER(a_take_needs_job, w_job_take && !w_job_valid, "frame taken from empty queue")
    `CFSA_NEVER(a_count_capped, w_job_valid && (w_job.byte_count > cfsa_pkg::MAX_BYTES), "data byte count above eight")
    `CFSA_ASSERT(a_take_frees_slot, (w_job_take && full) |=> !full, "queue stays full after a take")

endmodule

// File: dv/slcan_line_checker.sv
`timescale 1ns / 1ps

module slcan_line_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    input  logic        full,
    input  logic [28:0] i_frame_id,
    input  logic        i_is_extended,
    input  logic        i_is_remote,
    input  logic [3:0]  i_length_code,
    input  logic [63:0] i_payload,
    input  logic        empty,
    input  logic        pop,
    input  logic [7:0]  i_ascii_char,
    input  logic        i_end_of_line,
    output int          o_mismatches,
    output int          o_pending,
    output int          o_chars_seen
);

    localparam logic [7:0] LETTER_A   = 8'h41;
    localparam int         BYTES_CAP  = 8;
    localparam int         PRINT_CAP  = 100;

    typedef struct packed {
        logic [7:0] ch;
        logic       eol;
    } t_line_char;

    t_line_char line_q[$];

    initial begin
        o_mismatches = 0;
        o_chars_seen = 0;
    end

    assign o_pending = line_q.size();

    function automatic logic [7:0] nibble_ascii(input logic [3:0] nib);
        logic [7:0] w;
        w = {4'h0, nib};
        return (nib < 4'd10) ? (cfsa_pkg::CH_ZERO + w) : (LETTER_A + w - 8'd10);
    endfunction

    function automatic void add_char(input logic [7:0] ch, input logic eol);
        t_line_char c;
        c.ch  = ch;
        c.eol = eol;
        line_q.push_back(c);
    endfunction

    // Build the expected SLCAN line of one frame, character by character.
    function automatic void queue_line(input logic [28:0] id, input logic ext,
                                       input logic rtr, input logic [3:0] dlc,
                                       input logic [63:0] data);
        logic [7:0]  letter;
        logic [31:0] id32;
        logic [7:0]  b;
        int          nbytes;
        if (rtr)
            letter = ext ? cfsa_pkg::CH_EXT_REMOTE : cfsa_pkg::CH_STD_REMOTE;
        else
            letter = ext ? cfsa_pkg::CH_EXT_DATA : cfsa_pkg::CH_STD_DATA;
        add_char(letter, 1'b0);
        if (ext) begin
            id32 = {3'b000, id};
            for (int k = 7; k >= 0; k--)
                add_char(nibble_ascii(id32[4*k +: 4]), 1'b0);
        end else begin
            // bits above 10 are dropped for a standard id
            add_char(cfsa_pkg::CH_ZERO + {5'b00000, id[10:8]}, 1'b0);
            add_char(nibble_ascii(id[7:4]), 1'b0);
            add_char(nibble_ascii(id[3:0]), 1'b0);
        end
        add_char({cfsa_pkg::LEN_PREFIX, dlc}, 1'b0);
        nbytes = (int'(dlc) > BYTES_CAP) ? BYTES_CAP : int'(dlc);
        for (int i = 0; i < nbytes; i++) begin
            b = data[8*i +: 8];
            add_char(nibble_ascii(b[7:4]), 1'b0);
            add_char(nibble_ascii(b[3:0]), 1'b0);
        end
        add_char(cfsa_pkg::CH_CR, 1'b1);
    endfunction

    task automatic report_mismatch(input string msg);
        // keep the log short on a badly broken block
        if (o_mismatches < PRINT_CAP)
            $display("mismatch at %0t ns: %s", $time, msg);
        o_mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_line_char want;
        if (i_rst_n) begin
            if (pop && !empty) begin
                o_chars_seen++;
                if (line_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected char 0x%02h eol %0b",
                                              i_ascii_char, i_end_of_line));
                end else begin
                    want = line_q.pop_front();
                    if (i_ascii_char !== want.ch)
                        report_mismatch($sformatf("char 0x%02h, expected 0x%02h",
                                                  i_ascii_char, want.ch));
                    if (i_end_of_line !== want.eol)
                        report_mismatch($sformatf("end_of_line %0b, expected %0b on 0x%02h",
                                                  i_end_of_line, want.eol, want.ch));
                end
            end
            if (push && !full)
                queue_line(i_frame_id, i_is_extended, i_is_remote, i_length_code, i_payload);
        end
    end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_ITEMS  = 57;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [28:0] i_frame_id;
    logic        i_is_extended;
    logic        i_is_remote;
    logic [3:0]  i_length_code;
    logic [63:0] i_payload;
    logic        empty;
    logic        pop;
    logic [7:0]  o_ascii_char;
    logic        o_end_of_line;

    int mismatches;
    int pending_chars;
    int chars_seen;
    int frames_sent;
    int send_idle_pct;
    int pop_stall_pct;
    int quiet_cycles;

    can_frame_to_slcan_ascii uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_frame_id    (i_frame_id),
        .i_is_extended (i_is_extended),
        .i_is_remote   (i_is_remote),
        .i_length_code (i_length_code),
        .i_payload     (i_payload),
        .empty         (empty),
        .pop           (pop),
        .o_ascii_char  (o_ascii_char),
        .o_end_of_line (o_end_of_line)
    );

    slcan_line_checker u_line_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_frame_id    (i_frame_id),
        .i_is_extended (i_is_extended),
        .i_is_remote   (i_is_remote),
        .i_length_code (i_length_code),
        .i_payload     (i_payload),
        .empty         (empty),
        .pop           (pop),
        .i_ascii_char  (o_ascii_char),
        .i_end_of_line (o_end_of_line),
        .o_mismatches  (mismatches),
        .o_pending     (pending_chars),
        .o_chars_seen  (chars_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        pop_stall_pct = 0;
        pop <= 1'b0;
        forever begin
            @(posedge i_clk);
            pop <= ($urandom_range(99) >= pop_stall_pct);
        end
    end

    // End the run when nothing has moved on either side for too long.
    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((push && !full) || (pop && !empty))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    task automatic send_frame(input logic [28:0] id, input logic ext, input logic rtr,
                              input logic [3:0] dlc, input logic [63:0] data);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push          <= 1'b1;
        i_frame_id    <= id;
        i_is_extended <= ext;
        i_is_remote   <= rtr;
        i_length_code <= dlc;
        i_payload     <= data;
        @(posedge i_clk);
        while (full)
            @(posedge i_clk);
        frames_sent++;
    endtask

    task automatic send_random_frames(input int count);
        logic [28:0] id;
        logic [3:0]  dlc;
        for (int n = 0; n < count; n++) begin
            id  = 29'($urandom);
            // some short ids so the top digits are often zero
            if ($urandom_range(3) == 0)
                id = id & 29'h7FF;
            dlc = 4'($urandom_range(15));
            send_frame(id, 1'($urandom_range(1)), ($urandom_range(3) == 0), dlc,
                       {$urandom, $urandom});
        end
    endtask

    initial begin
        frames_sent   = 0;
        send_idle_pct = 0;
        i_rst_n       <= 1'b0;
        push          <= 1'b0;
        i_frame_id    <= '0;
        i_is_extended <= 1'b0;
        i_is_remote   <= 1'b0;
        i_length_code <= '0;
        i_payload     <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed frames: field extremes, all four types, long length codes
        send_frame(29'h0,        1'b0, 1'b0, 4'd0,  64'h0);
        send_frame(29'h7FF,      1'b0, 1'b0, 4'd8,  64'hFFFF_FFFF_FFFF_FFFF);
        send_frame(29'h1FFF_FFFF, 1'b0, 1'b0, 4'd1, 64'h0000_0000_0000_00A5);
        send_frame(29'h1FFF_F800, 1'b0, 1'b0, 4'd2, 64'h0000_0000_0000_5A3C);
        send_frame(29'h1FFF_FFFF, 1'b1, 1'b0, 4'd8, 64'h0123_4567_89AB_CDEF);
        send_frame(29'h0,        1'b1, 1'b0, 4'd0,  64'h0);
        send_frame(29'h1234_5678, 1'b1, 1'b0, 4'd4, 64'hFEDC_BA98_7654_3210);
        send_frame(29'h123,      1'b0, 1'b1, 4'd0,  64'h0);
        send_frame(29'h456,      1'b0, 1'b1, 4'd8,  64'hA5A5_A5A5_A5A5_A5A5);
        send_frame(29'h1ABC_DEF0, 1'b1, 1'b1, 4'd15, 64'h5A5A_5A5A_5A5A_5A5A);
        send_frame(29'h0ACE_0000, 1'b1, 1'b1, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        for (int c = 9; c <= 15; c++)
            send_frame(29'(29'h555 + c), 1'b0, 1'b0, 4'(c), 64'h8040_2010_0804_0201 << c);
        send_frame(29'h2AA,      1'b0, 1'b0, 4'd3,  64'h0000_0000_00C3_96E1);
        send_frame(29'h0F0F_0F0F, 1'b1, 1'b0, 4'd7, 64'h00F7_E6D5_C4B3_A291);
        send_frame(29'h1555_5555, 1'b1, 1'b0, 4'd5, 64'h0000_00AA_5500_FF11);

        // random frames under four flow-control settings
        send_random_frames(PHASE_ITEMS);
        send_idle_pct = 84;
        send_random_frames(PHASE_ITEMS);
        send_idle_pct = 0;
        pop_stall_pct = 84;
        send_random_frames(PHASE_ITEMS);
        send_idle_pct = 31;
        pop_stall_pct = 31;
        send_random_frames(PHASE_ITEMS);
        push <= 1'b0;

        pop_stall_pct = 0;
        // let the checker queue the last line before waiting on it
        @(posedge i_clk);
        while (pending_chars != 0)
            @(posedge i_clk);
        // catch any stray characters after the last line
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d frames of all four types and length codes 0..15,", frames_sent);
        $display("%0d characters compared across four flow-control phases", chars_seen);
        if (mismatches == 0 && pending_chars == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/cfsa_pkg.sv
rtl/cfsa_front.sv
rtl/cfsa_back.sv
rtl/can_frame_to_slcan_ascii.sv
dv/slcan_line_checker.sv
dv/tb.sv
